@@ rtl/mca_pkg.sv @@
// Package: coherence state, message and send codes shared by the agent modules
`timescale 1ns / 1ps
`default_nettype none

package mca_pkg;

    localparam int unsigned BlockW = 32;

    typedef enum logic [2:0] {
        ST_I  = 3'd0,
        ST_S  = 3'd1,
        ST_E  = 3'd2,
        ST_M  = 3'd3,
        ST_IS = 3'd4,
        ST_IM = 3'd5,
        ST_SM = 3'd6,
        ST_EM = 3'd7
    } t_state;

    typedef enum logic [2:0] {
        K_LOAD  = 3'd0,
        K_STORE = 3'd1,
        K_INV   = 3'd2,
        K_RECI  = 3'd3,
        K_RECS  = 3'd4,
        K_DATA  = 3'd5,
        K_DATAE = 3'd6,
        K_ACK   = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        SND_NONE   = 3'd0,
        SND_GETS   = 3'd1,
        SND_GETM   = 3'd2,
        SND_GETX   = 3'd3,
        SND_DPROC  = 3'd4,
        SND_DDIR   = 3'd5,
        SND_INVACK = 3'd6
    } t_send;

    localparam logic MODE_PROC = 1'b0;

    typedef struct packed {
        t_send  send;
        logic   miss;
        logic   illegal;
        t_state state_next;
    } t_step;

endpackage

`default_nettype wire

@@ rtl/mca_fsm.sv @@
// Coherence state register and transition table for one beat
`timescale 1ns / 1ps
`default_nettype none

module mca_fsm
    import mca_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire logic  i_mode,
    input  wire t_kind i_kind,
    output t_step      o_step
);

    t_state r_state;
    t_state n_state;
    t_send  n_send;
    logic   n_miss;
    logic   n_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_I;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        n_send  = SND_NONE;
        n_miss  = 1'b0;
        n_ok    = 1'b0;
        if (i_mode == MODE_PROC) begin
            if (i_kind == K_LOAD || i_kind == K_STORE) begin
                unique case (r_state)
                    ST_I: begin
                        n_ok   = 1'b1;
                        n_miss = 1'b1;
                        n_send = (i_kind == K_LOAD) ? SND_GETS : SND_GETM;
                        n_state = (i_kind == K_LOAD) ? ST_IS : ST_IM;
                    end
                    ST_S: begin
                        n_ok   = 1'b1;
                        n_send = (i_kind == K_LOAD) ? SND_DPROC : SND_GETM;
                        n_state = (i_kind == K_LOAD) ? ST_S : ST_SM;
                    end
                    ST_E: begin
                        n_ok   = 1'b1;
                        n_send = (i_kind == K_LOAD) ? SND_DPROC : SND_GETX;
                        n_state = (i_kind == K_LOAD) ? ST_E : ST_EM;
                    end
                    ST_M: begin
                        n_ok   = 1'b1;
                        n_send = SND_DPROC;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
        end else begin
            unique case (r_state)
                ST_S: begin
                    if (i_kind == K_INV) begin
                        n_ok = 1'b1; n_send = SND_INVACK; n_state = ST_I;
                    end
                end
                ST_E, ST_M: begin
                    if (i_kind == K_RECI) begin
                        n_ok = 1'b1; n_send = SND_DDIR; n_state = ST_I;
                    end else if (i_kind == K_RECS) begin
                        n_ok = 1'b1; n_send = SND_DDIR; n_state = ST_S;
                    end
                end
                ST_IS: begin
                    if (i_kind == K_DATA) begin
                        n_ok = 1'b1; n_send = SND_DPROC; n_state = ST_S;
                    end else if (i_kind == K_DATAE) begin
                        n_ok = 1'b1; n_send = SND_DPROC; n_state = ST_E;
                    end
                end
                ST_IM: begin
                    if (i_kind == K_DATA) begin
                        n_ok = 1'b1; n_send = SND_DPROC; n_state = ST_M;
                    end
                end
                ST_SM: begin
                    if (i_kind == K_INV) begin
                        n_ok = 1'b1; n_send = SND_INVACK; n_state = ST_IM;
                    end else if (i_kind == K_ACK || i_kind == K_DATA) begin
                        n_ok = 1'b1; n_send = SND_DPROC; n_state = ST_M;
                    end
                end
                ST_EM: begin
                    if (i_kind == K_RECI) begin
                        n_ok = 1'b1; n_send = SND_DDIR; n_state = ST_IM;
                    end else if (i_kind == K_RECS) begin
                        n_ok = 1'b1; n_send = SND_DDIR; n_state = ST_SM;
                    end else if (i_kind == K_ACK || i_kind == K_DATA) begin
                        n_ok = 1'b1; n_send = SND_DPROC; n_state = ST_M;
                    end
                end
                default: begin
                    n_ok = 1'b0;
                end
            endcase
        end
        if (!n_ok) begin
            n_state = r_state;
            n_send  = SND_NONE;
            n_miss  = 1'b0;
        end
        o_step.send       = n_send;
        o_step.miss       = n_miss;
        o_step.illegal    = !n_ok;
        o_step.state_next = n_state;
    end

endmodule

`default_nettype wire

@@ rtl/mesi_cache_agent_fsm.sv @@
// Top level: MESI cache-side coherence agent with input and result registers
`timescale 1ns / 1ps
`default_nettype none

// One beat in, one result beat out, every beat. A beat lands in the input
// register, passes the transition table and the coherence state register,
// and is shown from the result register; the agent takes one beat per cycle
// while the result is not stalled. The state register advances only as
// a beat moves from the input register to the result register, so a stalled
// result holds everything behind it. Illegal beats leave the state alone and
// report illegal with send none.
module mesi_cache_agent_fsm
    import mca_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_mode,
    input  wire logic [2:0]        i_kind,
    input  wire logic [BlockW-1:0] i_block,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [2:0]             o_send,
    output logic [BlockW-1:0]      o_block_out,
    output logic                   o_miss,
    output logic                   o_illegal,
    output logic [2:0]             o_state_now
);

    logic              r_in_vld;
    logic              r_mode;
    t_kind             r_kind;
    logic [BlockW-1:0] r_block;
    logic              r_out_vld;
    t_step             r_step;
    logic [BlockW-1:0] r_block_out;
    logic              adv_out;
    logic              fire;
    t_step             step;

    assign adv_out = !r_out_vld || !i_stall;
    assign fire    = r_in_vld && adv_out;
    assign o_stall = r_in_vld && !adv_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_mode  <= i_mode;
            r_kind  <= t_kind'(i_kind);
            r_block <= i_block;
        end
    end

    mca_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_mode  (r_mode),
        .i_kind  (r_kind),
        .o_step  (step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv_out) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_step      <= step;
            r_block_out <= r_block;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_send      = r_step.send;
    assign o_block_out = r_block_out;
    assign o_miss      = r_step.miss;
    assign o_illegal   = r_step.illegal;
    assign o_state_now = r_step.state_next;

    a_illegal_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_step.illegal |-> r_step.send == SND_NONE && !r_step.miss)
        else $error("illegal beat carries a message or miss");

    a_miss_transient : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_step.miss |->
            r_step.state_next == ST_IS || r_step.state_next == ST_IM)
        else $error("miss without move to a pending state");

    a_no_drop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> r_out_vld)
        else $error("stalled result lost");

    a_stall_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld)
        else $error("input stalled with room downstream");

endmodule

`default_nettype wire
